>>> rtl/tvpt_pkg.sv
`default_nettype none
package tvpt_pkg;

  // operation codes
  localparam logic [2:0] OP_RX_BYTE = 3'd0;
  localparam logic [2:0] OP_TICK    = 3'd1;
  localparam logic [2:0] OP_PWR_KEY = 3'd2;
  localparam logic [2:0] OP_QUERY   = 3'd3;
  localparam logic [2:0] OP_WAKE    = 3'd4;

  // power states
  localparam logic [2:0] PS_OFF         = 3'd0;
  localparam logic [2:0] PS_POWER_OFF   = 3'd1;
  localparam logic [2:0] PS_POWERING_OFF = 3'd2;
  localparam logic [2:0] PS_POWER_UP    = 3'd3;
  localparam logic [2:0] PS_POWERING_UP = 3'd4;
  localparam logic [2:0] PS_ON          = 3'd5;

  // query kinds
  localparam logic [1:0] QK_POWER_OFF = 2'd0;
  localparam logic [1:0] QK_POWER_ON  = 2'd1;
  localparam logic [1:0] QK_STATUS    = 2'd2;

  // configuration register indexes
  localparam logic CFG_RX_GAP       = 1'b0;
  localparam logic CFG_QUERY_PERIOD = 1'b1;

  localparam logic [6:0] RX_GAP_RESET       = 7'd100;
  localparam logic [6:0] QUERY_PERIOD_RESET = 7'd100;

  // reply characters
  localparam logic [7:0] CH_END = 8'h78;  // 'x'
  localparam logic [7:0] CH_M   = 8'h6d;  // 'm'
  localparam logic [7:0] CH_O   = 8'h4f;
  localparam logic [7:0] CH_K   = 8'h4b;
  localparam logic [7:0] CH_N   = 8'h4e;
  localparam logic [7:0] CH_G   = 8'h47;

  localparam logic [3:0] POS_CMD      = 4'd0;
  localparam logic [3:0] POS_ACK1     = 4'd5;
  localparam logic [3:0] POS_ACK2     = 4'd6;
  localparam logic [3:0] POS_SHORT_END = 4'd7;
  localparam logic [3:0] POS_LONG_END = 4'd8;
  localparam logic [3:0] POS_MAX      = 4'd15;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] rx_byte;
    logic [6:0] tick_count;
    logic       source_known;
  } in_item_t;

  typedef struct packed {
    logic [2:0] power_state;
    logic       send_query;
    logic [1:0] query_kind;
    logic       notify_source_off;
    logic       select_input_request;
  } out_item_t;

  // tracker state; timers are two's complement, running while not negative
  typedef struct packed {
    logic [2:0] power_state;
    logic [3:0] rx_position;
    logic [7:0] reply_command;
    logic [7:0] ack_first;
    logic [7:0] ack_second;
    logic [7:0] rx_gap_timer;
    logic [7:0] query_timer;
  } tvpt_state_t;

endpackage
`default_nettype wire

>>> rtl/tvpt_step.sv
`default_nettype none
module tvpt_step (
  input  tvpt_pkg::tvpt_state_t cur,
  input  tvpt_pkg::in_item_t    item,
  input  logic [6:0]            rx_gap_ticks,
  input  logic [6:0]            query_period_ticks,
  output tvpt_pkg::tvpt_state_t nxt,
  output tvpt_pkg::out_item_t   res
);
  import tvpt_pkg::*;

  logic [3:0] pos_eff;
  logic       finish;
  logic       query_due;

  assign pos_eff   = cur.rx_gap_timer[7] ? POS_CMD : cur.rx_position;
  assign query_due = cur.query_timer[7] || (cur.query_timer == 8'd0);

  always_comb begin
    nxt    = cur;
    res    = '0;
    finish = 1'b0;

    case (item.operation)
      OP_RX_BYTE: begin
        nxt.rx_gap_timer = {1'b0, rx_gap_ticks};
        if (item.rx_byte == CH_END) begin
          finish          = (pos_eff == POS_SHORT_END);
          nxt.rx_position = POS_CMD;
        end else begin
          if (pos_eff == POS_CMD) nxt.reply_command = item.rx_byte;
          if (pos_eff == POS_ACK1) nxt.ack_first = item.rx_byte;
          if (pos_eff == POS_ACK2) nxt.ack_second = item.rx_byte;
          finish          = (pos_eff == POS_LONG_END);
          nxt.rx_position = (pos_eff == POS_MAX) ? POS_MAX : pos_eff + 4'd1;
        end
      end
      OP_TICK: begin
        // a running timer is 0..127, so one step of up to 127 never passes -128
        if (!cur.rx_gap_timer[7])
          nxt.rx_gap_timer = cur.rx_gap_timer - {1'b0, item.tick_count};
        if (!cur.query_timer[7])
          nxt.query_timer = cur.query_timer - {1'b0, item.tick_count};
      end
      OP_PWR_KEY: begin
        if (cur.power_state == PS_ON) begin
          nxt.power_state       = PS_POWER_OFF;
          res.notify_source_off = 1'b1;
        end else if (cur.power_state == PS_OFF) begin
          nxt.power_state          = PS_POWER_UP;
          res.select_input_request = item.source_known;
        end
      end
      OP_QUERY: begin
        if (query_due) begin
          res.send_query  = 1'b1;
          nxt.query_timer = {1'b0, query_period_ticks};
          if (cur.power_state == PS_POWER_UP) begin
            res.query_kind  = QK_POWER_ON;
            nxt.power_state = PS_POWERING_UP;
          end else if (cur.power_state == PS_POWER_OFF) begin
            res.query_kind  = QK_POWER_OFF;
            nxt.power_state = PS_POWERING_OFF;
          end else begin
            res.query_kind = QK_STATUS;
            if (cur.power_state == PS_POWERING_UP) nxt.power_state = PS_POWER_UP;
            if (cur.power_state == PS_POWERING_OFF) nxt.power_state = PS_POWER_OFF;
          end
        end
      end
      OP_WAKE: begin
        if (cur.power_state < PS_POWER_UP) nxt.power_state = PS_POWER_UP;
      end
      default: ;
    endcase

    // completed reply, judged on the captured fields
    if (finish && cur.reply_command == CH_M) begin
      if (cur.ack_first == CH_O && cur.ack_second == CH_K) begin
        if (cur.power_state != PS_POWER_OFF && cur.power_state != PS_POWERING_OFF) begin
          res.select_input_request = (cur.power_state == PS_OFF) && item.source_known;
          nxt.power_state          = PS_ON;
        end
      end else if (cur.ack_first == CH_N && cur.ack_second == CH_G) begin
        if (cur.power_state != PS_POWER_UP && cur.power_state != PS_POWERING_UP) begin
          res.notify_source_off = (cur.power_state == PS_ON);
          nxt.power_state       = PS_OFF;
        end
      end
    end

    res.power_state = nxt.power_state;
  end

endmodule
`default_nettype wire

>>> rtl/tv_serial_reply_power_tracker.sv
// Power-state tracker for a TV on a serial command link. Each input item
// (reply byte, tick, power key, query slot, wake request) yields exactly one
// result item carrying the power state after that item plus query and pulse
// flags. One item is taken per clock when not stalled; its result is
// registered to out_, or to the skid stage if out_ is held. The whole update
// is one short combinational pass over a handful of registers; an output
// register backed by a one-deep skid stage lets the input keep flowing
// while a result waits, so in_stall only rises when both are full. The two
// configuration registers may be written at any time the block is idle.
`default_nettype none
module tv_serial_reply_power_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tvpt_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tvpt_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_wdata
);
  import tvpt_pkg::*;

  tvpt_state_t state_r;
  tvpt_state_t state_nxt;
  out_item_t   res;
  out_item_t   out_item_r;
  out_item_t   skid_item_r;
  logic        out_valid_r;
  logic        skid_valid_r;
  logic [6:0]  gap_r;
  logic [6:0]  period_r;
  logic        in_acc;
  logic        out_free;

  tvpt_step u_step (
    .cur                (state_r),
    .item               (in_item),
    .rx_gap_ticks       (gap_r),
    .query_period_ticks (period_r),
    .nxt                (state_nxt),
    .res                (res)
  );

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      gap_r        <= RX_GAP_RESET;
      period_r     <= QUERY_PERIOD_RESET;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RX_GAP:       gap_r    <= cfg_wdata;
          CFG_QUERY_PERIOD: period_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) state_r <= state_nxt;
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) out_item_r <= skid_item_r;
      else if (in_acc)  out_item_r <= res;
    end else if (in_acc) begin
      skid_item_r <= res;
    end
  end

  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.power_state <= PS_ON)
    else $error("power state out of range");

  a_kind_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.send_query |-> out_item.query_kind == QK_POWER_OFF)
    else $error("query kind set without a query");

  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.notify_source_off && out_item.select_input_request))
    else $error("notify and select pulses together");

  a_query_reload: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_item.operation == OP_QUERY
      && (state_r.query_timer[7] || state_r.query_timer == 8'd0)
    |=> state_r.query_timer == {1'b0, $past(period_r)})
    else $error("query timer not reloaded after a query");

endmodule
`default_nettype wire

>>> test/tv_serial_reply_power_tracker_check.sv
`timescale 1ns / 100ps
module tv_serial_reply_power_tracker_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tvpt_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tvpt_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_wdata,
  output int                  errors,
  output int                  pending,
  output int                  results_checked,
  output int                  replies_acted,
  output int                  queries_sent
);
  import tvpt_pkg::*;

  localparam int REPORT_LINES = 40;

  // own copy of the tracker state and settings
  logic [2:0]        power_now;
  logic [3:0]        byte_pos;
  logic [7:0]        cmd_char;
  logic [7:0]        ack_hi;
  logic [7:0]        ack_lo;
  logic signed [7:0] gap_left;
  logic signed [7:0] query_left;
  logic [6:0]        gap_setting;
  logic [6:0]        period_setting;

  out_item_t due_results[$];

  task automatic report(input string msg);
    errors++;
    if (errors <= REPORT_LINES)
      $display("%0t ERROR: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report($sformatf("%s is %0d, expected %0d", field, got, want));
  endtask

  // running timers drop by the tick count and stop at -128; negative ones hold
  function automatic logic signed [7:0] count_down(input logic signed [7:0] t,
                                                   input logic [6:0] d);
    int v;
    v = t;
    if (v >= 0) begin
      v = v - int'(d);
      if (v < -128)
        v = -128;
    end
    return 8'(v);
  endfunction

  // a complete reply: OK means on, NG means off, unless moving the other way
  task automatic apply_reply(input logic known, inout logic notify, inout logic sel);
    if (cmd_char == CH_M) begin
      if (ack_hi == CH_O && ack_lo == CH_K) begin
        replies_acted++;
        if (power_now != PS_POWERING_OFF && power_now != PS_POWER_OFF) begin
          if (power_now == PS_OFF && known)
            sel = 1'b1;
          power_now = PS_ON;
        end
      end else if (ack_hi == CH_N && ack_lo == CH_G) begin
        replies_acted++;
        if (power_now != PS_POWERING_UP && power_now != PS_POWER_UP) begin
          if (power_now == PS_ON)
            notify = 1'b1;
          power_now = PS_OFF;
        end
      end
    end
  endtask

  task automatic track_item(input in_item_t it, output out_item_t r);
    logic       notify;
    logic       sel;
    logic       send;
    logic [1:0] kind;
    logic [2:0] s;
    notify = 1'b0;
    sel = 1'b0;
    send = 1'b0;
    kind = QK_POWER_OFF;
    s = power_now;
    case (it.operation)
      OP_RX_BYTE: begin
        // stale partial reply after an idle gap
        if (gap_left < 0)
          byte_pos = POS_CMD;
        gap_left = $signed({1'b0, gap_setting});
        if (it.rx_byte == CH_END) begin
          if (byte_pos == POS_SHORT_END)
            apply_reply(it.source_known, notify, sel);
          byte_pos = POS_CMD;
        end else begin
          case (byte_pos)
            POS_CMD:      cmd_char = it.rx_byte;
            POS_ACK1:     ack_hi = it.rx_byte;
            POS_ACK2:     ack_lo = it.rx_byte;
            POS_LONG_END: apply_reply(it.source_known, notify, sel);
            default: ;
          endcase
          if (byte_pos < POS_MAX)
            byte_pos = byte_pos + 4'd1;
        end
      end
      OP_TICK: begin
        gap_left = count_down(gap_left, it.tick_count);
        query_left = count_down(query_left, it.tick_count);
      end
      OP_PWR_KEY: begin
        if (s == PS_ON) begin
          power_now = PS_POWER_OFF;
          notify = 1'b1;
        end else if (s == PS_OFF) begin
          power_now = PS_POWER_UP;
          sel = it.source_known;
        end
      end
      OP_QUERY: begin
        if (query_left <= 0) begin
          send = 1'b1;
          queries_sent++;
          if (s == PS_POWER_UP) begin
            kind = QK_POWER_ON;
            power_now = PS_POWERING_UP;
          end else if (s == PS_POWER_OFF) begin
            kind = QK_POWER_OFF;
            power_now = PS_POWERING_OFF;
          end else begin
            kind = QK_STATUS;
            if (s == PS_POWERING_UP)
              power_now = PS_POWER_UP;
            else if (s == PS_POWERING_OFF)
              power_now = PS_POWER_OFF;
          end
          query_left = $signed({1'b0, period_setting});
        end
      end
      OP_WAKE: begin
        if (s < PS_POWER_UP)
          power_now = PS_POWER_UP;
      end
      default: ;
    endcase
    r = '0;
    r.power_state = power_now;
    r.send_query = send;
    r.query_kind = kind;
    r.notify_source_off = notify;
    r.select_input_request = sel;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      power_now = PS_OFF;
      byte_pos = POS_CMD;
      cmd_char = '0;
      ack_hi = '0;
      ack_lo = '0;
      gap_left = '0;
      query_left = '0;
      gap_setting = RX_GAP_RESET;
      period_setting = QUERY_PERIOD_RESET;
      due_results.delete();
      errors = 0;
      results_checked = 0;
      replies_acted = 0;
      queries_sent = 0;
    end else begin
      // an item taken at this edge still sees the old settings
      if (in_valid && !in_stall) begin
        track_item(in_item, want);
        due_results.push_back(want);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_RX_GAP)
          gap_setting = cfg_wdata;
        else
          period_setting = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (due_results.size() == 0) begin
          report($sformatf("result item (power_state %0d) with nothing expected",
                           out_item.power_state));
        end else begin
          want = due_results.pop_front();
          check_field("power_state", 8'(out_item.power_state), 8'(want.power_state));
          check_field("send_query", 8'(out_item.send_query), 8'(want.send_query));
          check_field("query_kind", 8'(out_item.query_kind), 8'(want.query_kind));
          check_field("notify_source_off", 8'(out_item.notify_source_off),
                      8'(want.notify_source_off));
          check_field("select_input_request", 8'(out_item.select_input_request),
                      8'(want.select_input_request));
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

>>> test/tv_serial_reply_power_tracker_test.sv
`timescale 1ns / 100ps
module tv_serial_reply_power_tracker_test;
  import tvpt_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 4;
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;
  logic       cfg_we;
  logic       cfg_index;
  logic [6:0] cfg_wdata;

  int errors;
  int pending;
  int results_checked;
  int replies_acted;
  int queries_sent;
  int idle_pct;
  int stall_pct;
  int holds_asked;
  int items_sent;
  int cycle_count;

  tv_serial_reply_power_tracker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tv_serial_reply_power_tracker_check power_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .errors          (errors),
    .pending         (pending),
    .results_checked (results_checked),
    .replies_acted   (replies_acted),
    .queries_sent    (queries_sent)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, plus a long hold each time one is asked for
  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic in_item_t rand_item(input logic [2:0] op);
    in_item_t it;
    it.operation = op;
    it.rx_byte = 8'($urandom_range(255));
    it.tick_count = 7'($urandom_range(127));
    it.source_known = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == CH_END) ? CH_ZERO : b;
  endfunction

  task automatic offer_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    items_sent++;
  endtask

  task automatic offer_fields(input logic [2:0] op, input logic [7:0] b,
                              input logic [6:0] t, input logic k);
    in_item_t it;
    it.operation = op;
    it.rx_byte = b;
    it.tick_count = t;
    it.source_known = k;
    offer_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [6:0] gap, input logic [6:0] period);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RX_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_index <= CFG_QUERY_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one reply on the serial link, mostly well formed; some are cut short,
  // interrupted by a tick, padded past the end or carry odd acks
  task automatic reply_frame();
    logic [7:0] frame[$];
    logic [7:0] a1;
    logic [7:0] a2;
    logic       long_form;
    int         gap_at;
    in_item_t   it;
    if ($urandom_range(4) != 0)
      frame.push_back(CH_END);
    frame.push_back(($urandom_range(9) < 8) ? CH_M : 8'($urandom_range(255)));
    repeat (4) frame.push_back(filler_byte());
    case ($urandom_range(4))
      0, 1: begin
        a1 = CH_O;
        a2 = CH_K;
      end
      2, 3: begin
        a1 = CH_N;
        a2 = CH_G;
      end
      default: begin
        a1 = $urandom_range(1) ? CH_O : 8'($urandom_range(255));
        a2 = $urandom_range(1) ? CH_G : 8'($urandom_range(255));
      end
    endcase
    frame.push_back(a1);
    frame.push_back(a2);
    long_form = 1'($urandom_range(1));
    if (long_form) begin
      frame.push_back(filler_byte());
      frame.push_back(8'($urandom_range(255)));
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(9)) frame.push_back(filler_byte());
    end else begin
      frame.push_back(CH_END);
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(frame.size() - 1)) void'(frame.pop_back());
    end
    gap_at = ($urandom_range(7) == 0) ? $urandom_range(frame.size() - 1) : -1;
    foreach (frame[i]) begin
      if (i == gap_at)
        offer_item(rand_item(OP_TICK));
      it = rand_item(OP_RX_BYTE);
      it.rx_byte = frame[i];
      offer_item(it);
    end
  endtask

  task automatic random_traffic(input int count);
    int       start;
    int       r;
    in_item_t it;
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(99);
      if (r < 40) begin
        reply_frame();
      end else if (r < 55) begin
        it = rand_item(OP_TICK);
        if ($urandom_range(3) != 0)
          it.tick_count = 7'($urandom_range(8));
        offer_item(it);
      end else if (r < 67) begin
        offer_item(rand_item(OP_QUERY));
      end else if (r < 77) begin
        offer_item(rand_item(OP_PWR_KEY));
      end else if (r < 85) begin
        offer_item(rand_item(OP_WAKE));
      end else begin
        offer_item(rand_item(3'($urandom_range(7))));
      end
    end
  endtask

  // walk the power states once by hand, with the reset register values
  task automatic directed_items();
    offer_fields(OP_QUERY, 8'h00, 7'd0, 1'b0);
    offer_fields(OP_PWR_KEY, 8'h00, 7'd0, 1'b1);
    offer_fields(OP_TICK, 8'hff, 7'd127, 1'b0);
    offer_fields(OP_QUERY, 8'h00, 7'd0, 1'b0);
    offer_fields(OP_QUERY, 8'h00, 7'd0, 1'b1);
    // short OK reply while powering up
    offer_fields(OP_RX_BYTE, CH_M, 7'd0, 1'b0);
    offer_fields(OP_RX_BYTE, 8'h61, 7'd0, 1'b0);
    offer_fields(OP_RX_BYTE, CH_ZERO, 7'd0, 1'b0);
    offer_fields(OP_RX_BYTE, 8'h31, 7'd0, 1'b0);
    offer_fields(OP_RX_BYTE, 8'h20, 7'd0, 1'b0);
    offer_fields(OP_RX_BYTE, CH_O, 7'd0, 1'b0);
    offer_fields(OP_RX_BYTE, CH_K, 7'd0, 1'b0);
    offer_fields(OP_RX_BYTE, CH_END, 7'd127, 1'b1);
    offer_fields(OP_PWR_KEY, 8'h00, 7'd0, 1'b0);
    offer_fields(OP_TICK, 8'h00, 7'd0, 1'b1);
    offer_fields(OP_TICK, 8'h00, 7'd127, 1'b0);
    offer_fields(OP_QUERY, 8'hff, 7'd127, 1'b1);
    offer_fields(OP_WAKE, 8'h00, 7'd0, 1'b1);
    offer_fields(3'd7, 8'hff, 7'd127, 1'b1);
    offer_fields(3'd5, 8'h00, 7'd0, 1'b0);
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_RX_GAP;
    cfg_wdata <= '0;
    stall_pct <= 0;
    holds_asked <= 0;
    idle_pct = 0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    directed_items();

    wait_idle();
    set_config(7'd127, 7'd0);
    holds_asked <= holds_asked + 1;
    random_traffic(ITEMS_PER_PHASE);

    wait_idle();
    set_config(7'd0, 7'd127);
    idle_pct = 61;
    random_traffic(ITEMS_PER_PHASE);

    wait_idle();
    set_config(7'd5, 7'd3);
    idle_pct = 0;
    stall_pct <= 61;
    random_traffic(ITEMS_PER_PHASE);

    wait_idle();
    set_config(7'd60, 7'd20);
    idle_pct = 32;
    stall_pct <= 32;
    random_traffic(ITEMS_PER_PHASE);

    wait_idle();
    $display("Run covered %0d items over five gap and query period settings,",
             items_sent);
    $display("with idle, stall and long-hold phases: %0d results checked, %0d %s",
             results_checked, replies_acted, "on/off replies, queries sent below");
    $display("queries sent: %0d", queries_sent);
    if (errors == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> tv_serial_reply_power_tracker.f
rtl/tvpt_pkg.sv
rtl/tvpt_step.sv
rtl/tv_serial_reply_power_tracker.sv
test/tv_serial_reply_power_tracker_check.sv
test/tv_serial_reply_power_tracker_test.sv
